### hw/rtl/btr_pkg.sv
package btr_pkg;

  localparam int PIX_W  = 16;
  localparam int ADDR_W = 23;

  localparam logic [1:0] MODE_METRIC = 2'd0;
  localparam logic [1:0] MODE_ROW    = 2'd1;
  localparam logic [1:0] MODE_PEN    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  localparam logic [2:0] CFG_FIRST_CODE    = 3'd0;
  localparam logic [2:0] CFG_LAST_CODE     = 3'd1;
  localparam logic [2:0] CFG_INK_COLOR     = 3'd2;
  localparam logic [2:0] CFG_SURFACE_WIDTH = 3'd3;
  localparam logic [2:0] CFG_CLIP_LEFT     = 3'd4;
  localparam logic [2:0] CFG_CLIP_TOP      = 3'd5;
  localparam logic [2:0] CFG_CLIP_RIGHT    = 3'd6;
  localparam logic [2:0] CFG_CLIP_BOTTOM   = 3'd7;

  localparam logic signed [15:0] MISSING_ADVANCE = 16'sd5;

  typedef struct packed {
    logic mul;
    logic addx;
    logic step;
  } btr_ctl_t;

endpackage

### hw/rtl/bitmap_text_renderer_clipped.sv
// Bitmap font text blitter with a clip rectangle. Mode 0 and mode 1 requests load a glyph's
// metrics (lead, width, trail) and its row bitmaps into two on-chip RAMs; mode 2 places the
// pen. A mode 3 request draws one character: the block reads the metrics, forms the surface
// address of the top row with one multiply, then walks the glyph one row per cycle whenever
// the output register is free, stepping the address by surface_width in a shared adder, and
// gives GLYPH_HEIGHT results with the row mask clipped to [clip_left,clip_right) x
// [clip_top,clip_bottom). A drawn glyph occupies the block through the check, address and
// row-walk states; a code outside the font gives one empty result and advances the pen by 5.
// Stalls on out_ready add cycles. The input is not ready while a character is in progress;
// the output register lets the next request in while the final result waits. Reading a
// glyph that was never loaded returns whatever the RAM holds. Configuration writes are taken
// at any time but must only be issued while the block is idle.
module bitmap_text_renderer_clipped import btr_pkg::*; #(
  parameter int NUM_GLYPHS   = 256,
  parameter int GLYPH_HEIGHT = 16,
  parameter int ROW_BYTES    = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_mode,
  input  logic [7:0]               in_char_code,
  input  logic [7:0]               in_glyph_index,
  input  logic [3:0]               in_glyph_row,
  input  logic [15:0]              in_row_bits,
  input  logic signed [7:0]        in_lead_space,
  input  logic [7:0]               in_glyph_width,
  input  logic signed [7:0]        in_trail_space,
  input  logic signed [15:0]       in_start_x,
  input  logic signed [15:0]       in_start_y,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ADDR_W-1:0] out_pixel_address,
  output logic [PIX_W-1:0]         out_pixel_mask,
  output logic [15:0]              out_paint_color,
  output logic signed [15:0]       out_pen_x,
  output logic                     out_last,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam int ROW_PIXELS = (ROW_BYTES * 8 > PIX_W) ? PIX_W : ROW_BYTES * 8;
  localparam logic [PIX_W-1:0] ROW_MASK = PIX_W'((32'd1 << ROW_PIXELS) - 1);
  localparam int MAW   = (NUM_GLYPHS > 1) ? $clog2(NUM_GLYPHS) : 1;
  localparam int GDEPTH = NUM_GLYPHS * GLYPH_HEIGHT;
  localparam int GAW   = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int RW    = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CHK  = 5'b00010,
    ST_ADDX = 5'b00100,
    ST_ROWS = 5'b01000,
    ST_MISS = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  first_code_r, last_code_r;
  logic [15:0] ink_color_r;
  logic [11:0] surface_width_r, clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;

  logic signed [15:0] pen_col_r, pen_col_nxt;
  logic signed [15:0] pen_row_r, pen_row_nxt;
  logic signed [15:0] x_r, x_nxt;
  logic               miss_r;
  logic [GAW-1:0]     base_r;
  logic [RW-1:0]      row_r, row_nxt;
  logic               row_last;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [PIX_W-1:0]   out_mask_r;
  logic [15:0]        out_color_r;
  logic [15:0]        out_pen_r;
  logic               out_last_r;
  logic               out_free;
  logic               out_load;
  logic [ADDR_W-1:0]  load_addr;
  logic [PIX_W-1:0]   load_mask;
  logic               load_last;

  logic               in_acc;
  logic [8:0]         slot_w;
  logic               miss_w;
  logic [14:0]        base_w;
  logic [14:0]        gwaddr_w;

  logic               met_we, gl_we;
  logic [23:0]        met_rdata;
  logic [PIX_W-1:0]   gl_rdata;
  logic [GAW-1:0]     gl_raddr;

  btr_ctl_t              ctl;
  logic signed [ADDR_W-1:0] ru_addr;
  logic [PIX_W-1:0]      ru_mask;

  logic signed [15:0] lead_w, trail_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign slot_w   = {1'b0, in_char_code} - {1'b0, first_code_r};
  assign miss_w   = (in_char_code < first_code_r) || (in_char_code > last_code_r) ||
                    (slot_w >= 9'(NUM_GLYPHS));
  assign base_w   = 15'(slot_w[7:0]) * 15'(GLYPH_HEIGHT);
  assign gwaddr_w = 15'(in_glyph_index) * 15'(GLYPH_HEIGHT) + 15'(in_glyph_row);

  assign met_we = in_acc && (in_mode == MODE_METRIC) && (9'(in_glyph_index) < 9'(NUM_GLYPHS));
  assign gl_we  = in_acc && (in_mode == MODE_ROW) &&
                  (9'(in_glyph_index) < 9'(NUM_GLYPHS)) &&
                  (7'(in_glyph_row) < 7'(GLYPH_HEIGHT));

  assign gl_raddr = base_r + GAW'(row_nxt);

  btr_ram #(.WIDTH(24), .DEPTH(NUM_GLYPHS), .ADDR_W(MAW)) u_metric_ram (
    .clk   (clk),
    .we    (met_we),
    .waddr (in_glyph_index[MAW-1:0]),
    .wdata ({in_trail_space, in_glyph_width, in_lead_space}),
    .raddr (slot_w[MAW-1:0]),
    .rdata (met_rdata)
  );

  btr_ram #(.WIDTH(PIX_W), .DEPTH(GDEPTH), .ADDR_W(GAW)) u_glyph_ram (
    .clk   (clk),
    .we    (gl_we),
    .waddr (gwaddr_w[GAW-1:0]),
    .wdata (in_row_bits & ROW_MASK),
    .raddr (gl_raddr),
    .rdata (gl_rdata)
  );

  btr_row_unit #(.ROW_BYTES(ROW_BYTES)) u_row_unit (
    .clk           (clk),
    .ctl           (ctl),
    .pen_row       (pen_row_r),
    .surface_width (surface_width_r),
    .x             (x_r),
    .clip_left     (clip_left_r),
    .clip_top      (clip_top_r),
    .clip_right    (clip_right_r),
    .clip_bottom   (clip_bottom_r),
    .addr          (ru_addr),
    .mask_en       (ru_mask)
  );

  assign lead_w   = 16'($signed(met_rdata[7:0]));
  assign trail_w  = 16'($signed(met_rdata[23:16]));
  assign row_last = (row_r == RW'(GLYPH_HEIGHT - 1));

  always_comb begin
    state_nxt   = state_r;
    pen_col_nxt = pen_col_r;
    pen_row_nxt = pen_row_r;
    x_nxt       = x_r;
    row_nxt     = row_r;
    ctl         = '0;
    out_load    = 1'b0;
    load_addr   = '0;
    load_mask   = '0;
    load_last   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        row_nxt = '0;
        if (in_acc) begin
          unique case (in_mode)
            MODE_PEN: begin
              pen_col_nxt = in_start_x;
              pen_row_nxt = in_start_y;
            end
            MODE_DRAW: state_nxt = ST_CHK;
            default: ;
          endcase
        end
      end
      ST_CHK: begin
        if (miss_r) begin
          pen_col_nxt = pen_col_r + MISSING_ADVANCE;
          state_nxt   = ST_MISS;
        end else begin
          x_nxt       = pen_col_r + lead_w;
          pen_col_nxt = pen_col_r + lead_w + 16'(met_rdata[15:8]) + trail_w;
          ctl.mul     = 1'b1;
          state_nxt   = ST_ADDX;
        end
      end
      ST_ADDX: begin
        ctl.addx  = 1'b1;
        state_nxt = ST_ROWS;
      end
      ST_ROWS: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_addr = ru_addr;
          load_mask = gl_rdata & ru_mask;
          load_last = row_last;
          ctl.step  = 1'b1;
          row_nxt   = row_r + RW'(1);
          if (row_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MISS: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      pen_col_r       <= '0;
      pen_row_r       <= '0;
      row_r           <= '0;
      out_valid_r     <= 1'b0;
      first_code_r    <= 8'd32;
      last_code_r     <= 8'd127;
      ink_color_r     <= 16'hffff;
      surface_width_r <= 12'd800;
      clip_left_r     <= 12'd0;
      clip_top_r      <= 12'd0;
      clip_right_r    <= 12'd800;
      clip_bottom_r   <= 12'd600;
    end else begin
      state_r   <= state_nxt;
      pen_col_r <= pen_col_nxt;
      pen_row_r <= pen_row_nxt;
      row_r     <= row_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FIRST_CODE:    first_code_r    <= cfg_data[7:0];
          CFG_LAST_CODE:     last_code_r     <= cfg_data[7:0];
          CFG_INK_COLOR:     ink_color_r     <= cfg_data;
          CFG_SURFACE_WIDTH: surface_width_r <= cfg_data[11:0];
          CFG_CLIP_LEFT:     clip_left_r     <= cfg_data[11:0];
          CFG_CLIP_TOP:      clip_top_r      <= cfg_data[11:0];
          CFG_CLIP_RIGHT:    clip_right_r    <= cfg_data[11:0];
          CFG_CLIP_BOTTOM:   clip_bottom_r   <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (in_acc) begin
      miss_r <= miss_w;
      base_r <= base_w[GAW-1:0];
    end
    if (out_load) begin
      out_addr_r  <= load_addr;
      out_mask_r  <= load_mask;
      out_color_r <= ink_color_r;
      out_pen_r   <= pen_col_r;
      out_last_r  <= load_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = $signed(out_addr_r);
  assign out_pixel_mask    = out_mask_r;
  assign out_paint_color   = out_color_r;
  assign out_pen_x         = $signed(out_pen_r);
  assign out_last          = out_last_r;

  a_no_load_while_drawing: assert property (@(posedge clk) disable iff (!rst_n)
    (met_we || gl_we) |-> (state_r == ST_IDLE))
    else $error("glyph store written while a character is in progress");

  a_rows_start_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDX) |=> ((state_r == ST_ROWS) && (row_r == '0)))
    else $error("row walk did not start at the first glyph row");

  a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ROWS) && out_free && row_last) |=>
      ((state_r == ST_IDLE) && out_valid_r && out_last_r))
    else $error("final glyph row not flagged as last");

  a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MISS) && out_free) |=>
      (out_valid_r && out_last_r && (out_mask_r == '0) && (out_addr_r == '0)))
    else $error("missing code did not give one empty result");

endmodule

### hw/rtl/btr_ram.sv
module btr_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/btr_row_unit.sv
module btr_row_unit import btr_pkg::*; #(
  parameter int ROW_BYTES = 2
) (
  input  logic                     clk,
  input  btr_ctl_t                 ctl,
  input  logic signed [15:0]       pen_row,
  input  logic [11:0]              surface_width,
  input  logic signed [15:0]       x,
  input  logic [11:0]              clip_left,
  input  logic [11:0]              clip_top,
  input  logic [11:0]              clip_right,
  input  logic [11:0]              clip_bottom,
  output logic signed [ADDR_W-1:0] addr,
  output logic [PIX_W-1:0]         mask_en
);

  localparam int ROW_PIXELS = (ROW_BYTES * 8 > PIX_W) ? PIX_W : ROW_BYTES * 8;

  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic signed [17:0] y_r, y_nxt;
  logic [PIX_W-1:0]   col_mask_r, col_mask_nxt;
  logic signed [28:0] prod;
  logic               row_vis;

  assign prod = $signed(pen_row) * $signed({1'b0, surface_width});

  // column window over the glyph row, fixed for the whole character
  always_comb begin
    logic signed [17:0] c;
    c = '0;
    for (int b = 0; b < PIX_W; b++) begin
      c = 18'($signed({{2{x[15]}}, x}) + 18'(b));
      col_mask_nxt[b] = (b < ROW_PIXELS) &&
                        (c >= $signed({6'b0, clip_left})) &&
                        (c < $signed({6'b0, clip_right}));
    end
  end

  always_comb begin
    addr_nxt = addr_r;
    y_nxt    = y_r;
    priority if (ctl.mul) begin
      addr_nxt = prod[ADDR_W-1:0];
      y_nxt    = 18'(pen_row);
    end else if (ctl.addx) begin
      addr_nxt = addr_r + {{(ADDR_W-16){x[15]}}, x};
    end else if (ctl.step) begin
      addr_nxt = addr_r + ADDR_W'(surface_width);
      y_nxt    = y_r + 18'sd1;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    y_r    <= y_nxt;
    if (ctl.addx) begin
      col_mask_r <= col_mask_nxt;
    end
  end

  assign row_vis = (y_r >= $signed({6'b0, clip_top})) && (y_r < $signed({6'b0, clip_bottom}));
  assign addr    = $signed(addr_r);
  assign mask_en = row_vis ? col_mask_r : '0;

endmodule
